// File: src/sma_pkg.sv
// ----------------------------------------------------------------------------
// Scaled moving average package
// Register indexes, register widths and reset values shared by the unit and
// its checker.
// ----------------------------------------------------------------------------
package sma_pkg;

  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN          = 2'd1;

  localparam int unsigned WIN_BITS  = 7;
  localparam int unsigned GAIN_BITS = 16;
  localparam int unsigned AVG_BITS  = 32;

  // Q8.8 gain: the fraction bits dropped before the divide.
  localparam int unsigned GAIN_FRAC = 8;

  localparam logic [WIN_BITS-1:0]         WIN_RESET  = 7'd8;
  localparam logic signed [GAIN_BITS-1:0] GAIN_RESET = 16'sd256;

endpackage

// File: src/sma_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sma_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: src/scaled_moving_average_unit.sv
// ----------------------------------------------------------------------------
// Scaled moving average unit
// Running mean of the last window_length samples, scaled by a Q8.8 gain.
// ----------------------------------------------------------------------------
// One sample request is taken at a time. From its acceptance the request
// passes through the read, multiply, divider setup, divide and finish
// states, and the next sample is taken in the cycle after the result is
// loaded into the output register. In the divide state the restoring,
// bit-serial divider produces one quotient bit per cycle of the magnitude
// of gain * window_sum / 256, whose sign is applied afterwards, divided by
// the window length. The sample history lives in a RAM that is not cleared:
// a fill count marks which slots hold samples since the window was primed,
// and the others read as the priming sample. The first sample after reset,
// or after a change of window_length, fills the whole window with its value.
// A window length of zero acts as one, and one above WINDOW_MAX as WINDOW_MAX.
// The result waits in an output register, so a new sample can be taken while
// it is still stalled.
module scaled_moving_average_unit #(
  parameter int unsigned WINDOW_MAX  = 64,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [sma_pkg::CFG_IDX_BITS-1:0]      cfg_index_i,
  input  logic [sma_pkg::CFG_DATA_BITS-1:0]     cfg_data_i,
  input  logic                                  sample_valid_i,
  output logic                                  sample_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]         sample_i,
  output logic                                  average_valid_o,
  input  logic                                  average_stall_i,
  output logic signed [sma_pkg::AVG_BITS-1:0]   average_o
);

  localparam int unsigned AW     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned NW     = $clog2(WINDOW_MAX + 1);
  localparam int unsigned SUMW   = SAMPLE_BITS + $clog2(WINDOW_MAX) + 1;
  localparam int unsigned PW     = sma_pkg::GAIN_BITS + SUMW;
  localparam int unsigned DW     = PW - sma_pkg::GAIN_FRAC;
  localparam int unsigned CW     = $clog2(DW);
  localparam int unsigned CMPW   = (AW + 1 > NW) ? AW + 1 : NW;
  localparam int unsigned QXW    = DW + 33;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_PREP = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]                        state_q, state_d;
  logic [sma_pkg::WIN_BITS-1:0]      win_q;
  logic signed [sma_pkg::GAIN_BITS-1:0] gain_q;
  logic                              primed_q;
  logic [AW-1:0]                     wp_q;
  logic [NW-1:0]                     fill_q;
  logic signed [SAMPLE_BITS-1:0]     prime_q;
  logic signed [SUMW-1:0]            sum_q;
  logic signed [SAMPLE_BITS-1:0]     sample_q;
  logic signed [PW-1:0]              prod_q;
  logic [DW-1:0]                     div_q;
  logic [NW-1:0]                     rem_q;
  logic [CW-1:0]                     cnt_q;
  logic                              neg_q;
  logic                              out_valid_q;
  logic signed [sma_pkg::AVG_BITS-1:0] out_q;

  logic [NW-1:0]            n;
  logic                     in_accept;
  logic                     out_free;
  logic [SAMPLE_BITS-1:0]   ram_rdata;
  logic                     ram_we;
  logic signed [SAMPLE_BITS-1:0] old_sample;
  logic signed [SUMW-1:0]   prime_sum;
  logic signed [SUMW-1:0]   upd_sum;
  logic signed [PW-1:0]     prod_d;
  logic [PW-1:0]            mag;
  logic [AW:0]              wp_inc;
  logic [NW:0]              trial;
  logic                     qbit;
  logic [QXW-1:0]           qx;
  logic [sma_pkg::AVG_BITS-1:0] res;

  // Effective window: zero acts as one, large values clip to WINDOW_MAX.
  always_comb begin
    if (win_q == '0) begin
      n = NW'(1);
    end else if (32'(win_q) > WINDOW_MAX) begin
      n = NW'(WINDOW_MAX);
    end else begin
      n = NW'(win_q);
    end
  end

  assign in_accept      = sample_valid_i && (state_q == ST_IDLE);
  assign sample_stall_o = (state_q != ST_IDLE);
  assign out_free       = !out_valid_q || !average_stall_i;
  assign ram_we         = (state_q == ST_READ) && primed_q;

  // The read address is the write position, so the slot about to be
  // replaced is on the read port in the cycle after the request is taken.
  sma_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (sample_q),
    .raddr_i (wp_q),
    .rdata_o (ram_rdata)
  );

  assign old_sample = (CMPW'(wp_q) < CMPW'(fill_q)) ? $signed(ram_rdata) : prime_q;
  assign prime_sum  = sample_q * $signed({1'b0, n});
  assign upd_sum    = sum_q + SUMW'(sample_q) - SUMW'(old_sample);
  assign prod_d     = gain_q * sum_q;
  assign mag        = prod_q[PW-1] ? PW'(-prod_q) : PW'(prod_q);
  assign wp_inc     = {1'b0, wp_q} + (AW+1)'(1);

  assign trial = {rem_q, div_q[DW-1]};
  assign qbit  = (trial >= {1'b0, n});

  assign qx = QXW'(div_q);
  always_comb begin
    if (!neg_q && (qx > QXW'(32'h7fff_ffff))) begin
      res = 32'h7fff_ffff;
    end else if (neg_q && (qx > QXW'(33'h0_8000_0000))) begin
      res = 32'h8000_0000;
    end else if (neg_q) begin
      res = 32'd0 - qx[31:0];
    end else begin
      res = qx[31:0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_MUL;
      ST_MUL:  state_d = ST_PREP;
      ST_PREP: state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == CW'(DW - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_q       <= sma_pkg::WIN_RESET;
      gain_q      <= sma_pkg::GAIN_RESET;
      primed_q    <= 1'b0;
      wp_q        <= '0;
      fill_q      <= '0;
      prime_q     <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        if (cfg_index_i == sma_pkg::CFG_WINDOW_LENGTH) begin
          if (cfg_data_i[sma_pkg::WIN_BITS-1:0] != win_q) begin
            win_q    <= cfg_data_i[sma_pkg::WIN_BITS-1:0];
            primed_q <= 1'b0;
            wp_q     <= '0;
            fill_q   <= '0;
          end
        end else if (cfg_index_i == sma_pkg::CFG_GAIN) begin
          gain_q <= $signed(cfg_data_i[sma_pkg::GAIN_BITS-1:0]);
        end
      end

      if (state_q == ST_READ) begin
        if (!primed_q) begin
          prime_q  <= sample_q;
          sum_q    <= prime_sum;
          wp_q     <= '0;
          fill_q   <= '0;
          primed_q <= 1'b1;
        end else begin
          sum_q <= upd_sum;
          if (fill_q < n) begin
            fill_q <= fill_q + NW'(1);
          end
          if (CMPW'(wp_inc) >= CMPW'(n)) begin
            wp_q <= '0;
          end else begin
            wp_q <= wp_inc[AW-1:0];
          end
        end
      end

      if (state_q == ST_PREP) begin
        cnt_q <= '0;
      end else if (state_q == ST_DIV) begin
        cnt_q <= cnt_q + CW'(1);
      end

      if (state_q == ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!average_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sample_q <= sample_i;
    end
    if (state_q == ST_MUL) begin
      prod_q <= prod_d;
    end
    if (state_q == ST_PREP) begin
      div_q <= mag[PW-1:sma_pkg::GAIN_FRAC];
      rem_q <= '0;
      neg_q <= prod_q[PW-1];
    end else if (state_q == ST_DIV) begin
      // Restoring division: the quotient bits shift in behind the dividend.
      rem_q <= qbit ? NW'(trial - {1'b0, n}) : trial[NW-1:0];
      div_q <= {div_q[DW-2:0], qbit};
    end
    if (state_q == ST_FIN && out_free) begin
      out_q <= $signed(res);
    end
  end

  assign average_valid_o = out_valid_q;
  assign average_o       = out_q;

endmodule

// File: src/sma_checker.sv
// ----------------------------------------------------------------------------
// Scaled moving average checker
// Port-level checks on the output channel and the busy period of a request.
// ----------------------------------------------------------------------------
module sma_assert (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                sample_valid_i,
  input logic                                sample_stall_o,
  input logic                                average_valid_o,
  input logic                                average_stall_i,
  input logic signed [sma_pkg::AVG_BITS-1:0] average_o
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    average_valid_o && average_stall_i |=> average_valid_o)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    average_valid_o && average_stall_i |=> $stable(average_o))
    else $error("result changed while stalled");

  // The unit stays busy through the update, multiply and divider setup.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_valid_i && !sample_stall_o |=> sample_stall_o ##1 sample_stall_o
    ##1 sample_stall_o)
    else $error("sample request taken while the previous one is in work");

  // A new result appears only at the end of a busy period.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(average_valid_o) |-> $past(sample_stall_o))
    else $error("result appeared without a request in work");

endmodule

bind scaled_moving_average_unit sma_assert u_sma_assert (.*);

// File: test/sma_checker.sv
// ----------------------------------------------------------------------------
// Scaled moving average checker
// Watches the configuration port and both request channels of the unit,
// keeps its own window of samples and compares every result with the
// average it predicts.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sma_checker #(
  parameter int unsigned WINDOW_MAX  = 64,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sma_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [sma_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  logic                                sample_valid_i,
  input  logic                                sample_stall_i,
  input  logic signed [SAMPLE_BITS-1:0]       sample_i,
  input  logic                                average_valid_i,
  input  logic                                average_stall_i,
  input  logic signed [sma_pkg::AVG_BITS-1:0] average_i,
  output int unsigned                         fail_count_o,
  output int unsigned                         pending_o
);

  typedef logic signed [SAMPLE_BITS-1:0]       sample_t;
  typedef logic signed [sma_pkg::AVG_BITS-1:0] average_t;

  localparam longint AVG_MAX = (longint'(1) <<< (sma_pkg::AVG_BITS - 1)) - 1;
  localparam longint AVG_MIN = -(longint'(1) <<< (sma_pkg::AVG_BITS - 1));

  sample_t                              history [WINDOW_MAX];
  int unsigned                          next_slot;
  int unsigned                          filled;
  sample_t                              seed_sample;
  longint                               running_sum;
  bit                                   primed;
  logic [sma_pkg::WIN_BITS-1:0]         window_reg;
  logic signed [sma_pkg::GAIN_BITS-1:0] gain_reg;
  average_t                             expected_averages [$];
  average_t                             oldest;
  int unsigned                          failures;

  function automatic int unsigned window_span(input logic [sma_pkg::WIN_BITS-1:0] len);
    if (len == '0) return 1;
    if (32'(len) > WINDOW_MAX) return WINDOW_MAX;
    return 32'(len);
  endfunction

  function automatic void apply_register(input logic [sma_pkg::CFG_IDX_BITS-1:0] index,
                                         input logic [sma_pkg::CFG_DATA_BITS-1:0] data);
    case (index)
      sma_pkg::CFG_WINDOW_LENGTH: begin
        // Only a real change of length throws the window away.
        if (data[sma_pkg::WIN_BITS-1:0] != window_reg) begin
          window_reg = data[sma_pkg::WIN_BITS-1:0];
          next_slot  = 0;
          filled     = 0;
          primed     = 1'b0;
        end
      end
      sma_pkg::CFG_GAIN: begin
        gain_reg = data[sma_pkg::GAIN_BITS-1:0];
      end
      default: begin
      end
    endcase
  endfunction

  // Moves the window on by one sample and returns the scaled mean.
  function automatic average_t advance_window(input sample_t value);
    int unsigned n;
    int unsigned slot;
    sample_t     leaving;
    longint      q;
    n = window_span(window_reg);
    if (!primed) begin
      seed_sample = value;
      running_sum = longint'(value) * longint'(n);
      next_slot   = 0;
      filled      = 0;
      primed      = 1'b1;
    end else begin
      slot = next_slot % n;
      // Slots not written since priming still hold the priming sample.
      leaving = (slot < filled) ? history[slot] : seed_sample;
      running_sum += longint'(value) - longint'(leaving);
      history[slot] = value;
      if (filled < n) filled++;
      slot++;
      next_slot = (slot >= n) ? 0 : slot;
    end
    q = (longint'(gain_reg) * running_sum) / (longint'(n) << sma_pkg::GAIN_FRAC);
    if (q > AVG_MAX) q = AVG_MAX;
    if (q < AVG_MIN) q = AVG_MIN;
    return q[sma_pkg::AVG_BITS-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (history[i]) history[i] = '0;
      next_slot    = 0;
      filled       = 0;
      seed_sample  = '0;
      running_sum  = 0;
      primed       = 1'b0;
      window_reg   = sma_pkg::WIN_RESET;
      gain_reg     = sma_pkg::GAIN_RESET;
      failures     = 0;
      expected_averages.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) apply_register(cfg_index_i, cfg_data_i);
      // The result is matched before a new request is queued, since a result
      // can never belong to the sample taken at the same edge.
      if (average_valid_i && !average_stall_i) begin
        if (expected_averages.size() == 0) begin
          $error("average: expected none, got %0d", average_i);
          failures++;
        end else begin
          oldest = expected_averages.pop_front();
          if (average_i !== oldest) begin
            $error("average: expected %0d, got %0d", oldest, average_i);
            failures++;
          end
        end
      end
      if (sample_valid_i && !sample_stall_i) begin
        expected_averages.push_back(advance_window(sample_i));
      end
      fail_count_o <= failures;
      pending_o    <= expected_averages.size();
    end
  end

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// Scaled moving average testbench
// Drives samples and register writes into the unit under changing idle and
// stall patterns; a checker beside the unit predicts every average.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int unsigned SAMPLE_BITS   = 24;
  localparam int unsigned PHASE_ITEMS   = 420;
  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam int unsigned SETTLE_CYCLES = 60;

  // Indexes past the register list; writes there must be ignored.
  localparam logic [sma_pkg::CFG_IDX_BITS-1:0] CFG_SPARE_LOW  = 2'd2;
  localparam logic [sma_pkg::CFG_IDX_BITS-1:0] CFG_SPARE_HIGH = 2'd3;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 24'sh800000;

  logic                                 clk           = 1'b0;
  logic                                 rst_n         = 1'b0;
  logic                                 cfg_we        = 1'b0;
  logic [sma_pkg::CFG_IDX_BITS-1:0]     cfg_index     = '0;
  logic [sma_pkg::CFG_DATA_BITS-1:0]    cfg_data      = '0;
  logic                                 sample_valid  = 1'b0;
  logic                                 sample_stall;
  logic signed [SAMPLE_BITS-1:0]        sample_data   = '0;
  logic                                 average_valid;
  logic                                 average_stall = 1'b0;
  logic signed [sma_pkg::AVG_BITS-1:0]  average;
  int unsigned                          fail_count;
  int unsigned                          pending;

  int unsigned                          send_idle_pct  = 0;
  int unsigned                          recv_stall_pct = 0;
  int unsigned                          quiet_cycles   = 0;
  logic [sma_pkg::WIN_BITS-1:0]         cur_window     = sma_pkg::WIN_RESET;

  always #10 clk = ~clk;

  scaled_moving_average_unit #(
    .WINDOW_MAX  (64),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .sample_valid_i  (sample_valid),
    .sample_stall_o  (sample_stall),
    .sample_i        (sample_data),
    .average_valid_o (average_valid),
    .average_stall_i (average_stall),
    .average_o       (average)
  );

  sma_checker #(
    .WINDOW_MAX  (64),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .sample_valid_i  (sample_valid),
    .sample_stall_i  (sample_stall),
    .sample_i        (sample_data),
    .average_valid_i (average_valid),
    .average_stall_i (average_stall),
    .average_i       (average),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      average_stall <= 1'b0;
    end else begin
      average_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Any request or register write counts as progress.
  always @(posedge clk) begin
    if ((sample_valid && !sample_stall) || (average_valid && !average_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_data  <= value;
    do @(posedge clk); while (sample_stall);
  endtask

  task automatic wait_for_results();
    sample_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [sma_pkg::CFG_IDX_BITS-1:0] index,
                           input logic [sma_pkg::CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_window(input logic [sma_pkg::CFG_DATA_BITS-1:0] data);
    write_reg(sma_pkg::CFG_WINDOW_LENGTH, data);
    cur_window = data[sma_pkg::WIN_BITS-1:0];
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(7))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2, 3:    return SAMPLE_BITS'($urandom_range(200)) - SAMPLE_BITS'(100);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Bits above the length field are random; the unit must drop them.
  function automatic logic [sma_pkg::CFG_DATA_BITS-1:0] pick_window();
    logic [sma_pkg::WIN_BITS-1:0] len;
    case ($urandom_range(9))
      0:       len = '0;
      1:       len = 7'd1;
      2:       len = 7'd64;
      3:       len = sma_pkg::WIN_BITS'($urandom_range(127, 65));
      default: len = sma_pkg::WIN_BITS'($urandom_range(16, 2));
    endcase
    return {(sma_pkg::CFG_DATA_BITS - sma_pkg::WIN_BITS)'($urandom), len};
  endfunction

  function automatic logic [sma_pkg::CFG_DATA_BITS-1:0] pick_gain();
    case ($urandom_range(9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'h0100;
      default: return sma_pkg::CFG_DATA_BITS'($urandom);
    endcase
  endfunction

  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct);
    int unsigned sent;
    int unsigned burst;
    wait_for_results();
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    set_window(pick_window());
    write_reg(sma_pkg::CFG_GAIN, pick_gain());
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      burst = $urandom_range(120, 20);
      repeat (burst) send_sample(pick_sample());
      sent += burst;
      // The block is idle again before any register changes.
      wait_for_results();
      case ($urandom_range(5))
        0: set_window(pick_window());
        1: write_reg(sma_pkg::CFG_GAIN, pick_gain());
        2: begin
          set_window(pick_window());
          write_reg(sma_pkg::CFG_GAIN, pick_gain());
        end
        3: set_window({(sma_pkg::CFG_DATA_BITS - sma_pkg::WIN_BITS)'($urandom),
                       cur_window});
        4: write_reg($urandom_range(1) ? CFG_SPARE_LOW : CFG_SPARE_HIGH,
                     sma_pkg::CFG_DATA_BITS'($urandom));
        default: begin
        end
      endcase
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct  = 30;
    recv_stall_pct = 85;

    // Reset settings, full-scale samples.
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(0);
    send_sample(-1);
    send_sample(1);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    // Gain extremes keep the window.
    wait_for_results();
    write_reg(sma_pkg::CFG_GAIN, 16'h7FFF);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MIN);
    wait_for_results();
    write_reg(sma_pkg::CFG_GAIN, 16'h8000);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    // Rewriting the same length must not restart priming.
    wait_for_results();
    set_window(16'h0008);
    send_sample(123456);
    wait_for_results();
    write_reg(CFG_SPARE_LOW, 16'hFFFF);
    write_reg(CFG_SPARE_HIGH, 16'h0000);
    send_sample(-5);
    // A length of zero acts as one.
    wait_for_results();
    set_window(16'h0000);
    write_reg(sma_pkg::CFG_GAIN, 16'h0100);
    send_sample(1000);
    send_sample(-3);
    // All ones: length 127 is clamped to the largest window.
    wait_for_results();
    set_window(16'hFFFF);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(7);
    wait_for_results();
    set_window(16'h0001);
    write_reg(sma_pkg::CFG_GAIN, 16'h0180);
    send_sample(5);
    send_sample(-5);

    run_phase(30, 85);
    run_phase(85, 30);
    run_phase(0, 0);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
